[rtl/dol_pkg.sv]
package dol_pkg;

	localparam int HANDLE_W = 32;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_PRESENT   = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef struct packed {
		op_t                 operation;
		logic [HANDLE_W-1:0] handle;
		logic [POS_W-1:0]    position;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] entry_value;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic                add_go;
		logic                rm_go;
		logic [HANDLE_W-1:0] handle;
	} cell_ctl_t;

endpackage

[rtl/dol_chan_if.sv]
interface dol_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/dol_cell.sv]
module dol_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int IW  = 7
) (
	input  logic                          clk,
	input  dol_pkg::cell_ctl_t            ctl,
	input  logic [CW-1:0]                 count,
	input  logic [IW-1:0]                 pos,
	input  logic [dol_pkg::HANDLE_W-1:0]  nxt,
	input  logic                          shift_in,
	output logic [dol_pkg::HANDLE_W-1:0]  value,
	output logic                          hit,
	output logic                          shift_out,
	output logic [dol_pkg::HANDLE_W-1:0]  rd
);
	logic [dol_pkg::HANDLE_W-1:0] data_q;
	logic                         occupied;
	logic                         tail;
	logic                         sel;

	assign occupied  = count > CW'(IDX);
	assign tail      = count == CW'(IDX);
	assign sel       = occupied && (pos == IW'(IDX));
	assign hit       = occupied && (data_q == ctl.handle);
	assign shift_out = shift_in | hit;
	assign value     = data_q;
	assign rd        = sel ? data_q : '0;

	// remove pulls the upper neighbor down, add fills the first free cell
	always_ff @(posedge clk) begin
		if (ctl.rm_go && shift_out) begin
			data_q <= nxt;
		end else if (ctl.add_go && tail) begin
			data_q <= ctl.handle;
		end
	end
endmodule

[rtl/dedup_ordered_handle_list.sv]
// Ordered list of up to CAPACITY distinct 32-bit handles, one register cell
// per entry. Each cmd word is add, remove, clear or read, and gives exactly
// one result word with a status and the entry count after the operation.
// All cells compare against the handle in parallel, and a remove shifts the
// later entries down one cell in the same cycle, so one command is taken
// every clock; the result sits in an output register and a new command is
// accepted while it waits, as long as that register is freed in the same
// cycle. Add reports already present before list full; a read at or beyond
// the count returns zero with index out of range. Ports hold 64 entries at
// most (6-bit position).
module dedup_ordered_handle_list #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	dol_chan_if.sink    cmd,
	dol_chan_if.source  result
);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > dol_pkg::POS_W) ? CW : dol_pkg::POS_W;

	dol_pkg::req_t                req;
	dol_pkg::rsp_t                rsp_q;
	logic                         valid_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_d;
	logic                         accept;
	logic                         present;
	logic                         full;
	logic                         pos_ok;
	logic [IW-1:0]                pos_ix;
	dol_pkg::cell_ctl_t           ctl;
	dol_pkg::status_t             status_d;
	logic [dol_pkg::HANDLE_W-1:0] rd_any;

	logic [CAPACITY-1:0]          hit_vec;
	logic [CAPACITY:0]            shift_c;
	logic [dol_pkg::HANDLE_W-1:0] value_vec [CAPACITY];
	logic [dol_pkg::HANDLE_W-1:0] rd_vec    [CAPACITY];

	assign req        = cmd.data;
	assign cmd.ready  = !valid_q || result.ready;
	assign accept     = cmd.valid && cmd.ready;
	assign present    = |hit_vec;
	assign full       = count_q == CW'(CAPACITY);
	assign pos_ix     = IW'(req.position);
	assign pos_ok     = pos_ix < IW'(count_q);
	assign shift_c[0] = 1'b0;

	assign ctl.handle = req.handle;
	assign ctl.add_go = accept && (req.operation == dol_pkg::OP_ADD) && !present && !full;
	assign ctl.rm_go  = accept && (req.operation == dol_pkg::OP_REMOVE) && present;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [dol_pkg::HANDLE_W-1:0] nxt;

		if (i == CAPACITY - 1) begin : g_last
			assign nxt = value_vec[i];
		end else begin : g_mid
			assign nxt = value_vec[i+1];
		end

		dol_cell #(
			.IDX (i),
			.CW  (CW),
			.IW  (IW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.pos       (pos_ix),
			.nxt       (nxt),
			.shift_in  (shift_c[i]),
			.value     (value_vec[i]),
			.hit       (hit_vec[i]),
			.shift_out (shift_c[i+1]),
			.rd        (rd_vec[i])
		);
	end

	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | rd_vec[i];
		end
	end

	always_comb begin
		count_d  = count_q;
		status_d = dol_pkg::ST_DONE;
		unique case (req.operation)
			dol_pkg::OP_ADD: begin
				if (present) begin
					status_d = dol_pkg::ST_PRESENT;
				end else if (full) begin
					status_d = dol_pkg::ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			dol_pkg::OP_REMOVE: begin
				if (present) begin
					count_d = count_q - CW'(1);
				end else begin
					status_d = dol_pkg::ST_NOT_FOUND;
				end
			end
			dol_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			dol_pkg::OP_READ: begin
				if (!pos_ok) begin
					status_d = dol_pkg::ST_RANGE;
				end
			end
			default: begin
				status_d = dol_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= status_d;
			rsp_q.entry_value <= (req.operation == dol_pkg::OP_READ && pos_ok) ? rd_any : '0;
			rsp_q.entry_count <= dol_pkg::COUNT_W'(count_d);
		end
	end

	assign result.valid = valid_q;
	assign result.data  = rsp_q;
endmodule
